/* sv/hbsd_pkg.sv */
// ----------------------------------------------------------------------------
// hbsd_pkg
// shared types, constants and helpers for the bit-serial huffman decoder
// ----------------------------------------------------------------------------
package hbsd_pkg;

    localparam int MAX_CODE_LEN = 12;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int STORE_AW     = MAX_CODE_LEN + 1;
    localparam int STORE_DEPTH  = 1 << STORE_AW;
    localparam int SYM_W        = 8;
    localparam int ENTRY_W      = SYM_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_DECODE = 2'd2,
        OP_END    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESOLVE
    } t_state;

    typedef struct packed {
        t_opcode                   opcode;
        logic                      coded_bit;
        logic [MAX_CODE_LEN-1:0]   entry_code;
        logic [3:0]                entry_length;
        logic [SYM_W-1:0]          entry_symbol;
    } t_in_item;

    typedef struct packed {
        logic [SYM_W-1:0] decoded_symbol;
        logic             overlong;
    } t_out_item;

    typedef struct packed {
        logic take;
        logic sweep;
        logic resolve;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_done;
        logic result_pending;
        logic out_free;
    } t_dp_status;

    // a code of length len with bits code lives at (1 << len) | code
    function automatic logic [STORE_AW-1:0] table_index(
        input logic [LEN_W-1:0]        len,
        input logic [MAX_CODE_LEN-1:0] code
    );
        logic [STORE_AW-1:0] top;
        logic [STORE_AW-1:0] mask;
        top  = STORE_AW'(1) << len;
        mask = top - STORE_AW'(1);
        return top | ({1'b0, code} & mask);
    endfunction

endpackage

/* sv/huffman_bit_serial_decoder.sv */
// ----------------------------------------------------------------------------
// huffman_bit_serial_decoder
// bit-serial huffman decoder with a loadable code table
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+-----------------------------------
//   input   | i_in_valid  | o_in_stall  | i_in  (opcode, bit, code, len, sym)
//   output  | o_out_valid | i_out_stall | o_out (decoded_symbol, overlong)
//
// write and end beats leave the controller idle for the next beat; a decode
// beat does the registered table read, then resolves the hit and, on a result, clears the code.
// a clear beat sweeps the whole 8192-entry table, one entry a cycle, and
// the same sweep runs after reset before the first beat is taken.
// a decode result that meets a stalled full output register holds the
// decoder in its resolve cycle until the register drains.
// ----------------------------------------------------------------------------
module huffman_bit_serial_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  hbsd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output hbsd_pkg::t_out_item o_out
);

    hbsd_pkg::t_dp_cmd    cmd;
    hbsd_pkg::t_dp_status status;

    hbsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_in.opcode),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    hbsd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

/* sv/hbsd_datapath.sv */
// ----------------------------------------------------------------------------
// hbsd_datapath
// code table memory, code accumulator, clearing sweep and output register
// ----------------------------------------------------------------------------
module hbsd_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  hbsd_pkg::t_in_item  i_in,
    input  logic                i_out_stall,
    input  hbsd_pkg::t_dp_cmd   i_cmd,
    output hbsd_pkg::t_dp_status o_status,
    output logic                o_out_valid,
    output hbsd_pkg::t_out_item o_out
);

    logic [hbsd_pkg::ENTRY_W-1:0]      r_mem [hbsd_pkg::STORE_DEPTH];
    logic [hbsd_pkg::ENTRY_W-1:0]      r_rd_data;
    logic [hbsd_pkg::STORE_AW-1:0]     r_sweep_cnt;
    logic [hbsd_pkg::MAX_CODE_LEN-1:0] r_acc;
    logic [hbsd_pkg::LEN_W-1:0]        r_len;
    logic                              r_out_valid;
    hbsd_pkg::t_out_item               r_out;

    logic [hbsd_pkg::MAX_CODE_LEN-1:0] n_acc;
    logic [hbsd_pkg::LEN_W-1:0]        n_len;
    logic [hbsd_pkg::LEN_W-1:0]        wr_len;
    logic                              wr_len_ok;
    logic                              mem_we;
    logic [hbsd_pkg::STORE_AW-1:0]     mem_wa;
    logic [hbsd_pkg::ENTRY_W-1:0]      mem_wd;
    logic [hbsd_pkg::STORE_AW-1:0]     mem_ra;
    logic                              rd_en;
    logic                              hit;
    logic                              at_max;
    logic                              result;

    // next accumulator value for a decode beat
    always_comb begin
        n_acc = {r_acc[hbsd_pkg::MAX_CODE_LEN-2:0], i_in.coded_bit};
        if (r_len < hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN)) begin
            n_len = r_len + hbsd_pkg::LEN_W'(1);
        end else begin
            n_len = r_len;
        end
    end

    assign wr_len    = hbsd_pkg::LEN_W'(i_in.entry_length);
    assign wr_len_ok = (i_in.entry_length != 4'd0)
                    && ({1'b0, i_in.entry_length} <= 5'(hbsd_pkg::MAX_CODE_LEN));

    always_comb begin
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
            mem_wa = r_sweep_cnt;
            mem_wd = '0;
        end else begin
            mem_we = i_cmd.take && (i_in.opcode == hbsd_pkg::OP_WRITE) && wr_len_ok;
            mem_wa = hbsd_pkg::table_index(wr_len, i_in.entry_code);
            mem_wd = {1'b1, i_in.entry_symbol};
        end
    end

    assign rd_en  = i_cmd.take && (i_in.opcode == hbsd_pkg::OP_DECODE);
    assign mem_ra = hbsd_pkg::table_index(n_len, n_acc);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[mem_ra];
        end
    end

    assign hit    = r_rd_data[hbsd_pkg::ENTRY_W-1];
    assign at_max = (r_len == hbsd_pkg::LEN_W'(hbsd_pkg::MAX_CODE_LEN));
    assign result = hit || at_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_cnt <= '0;
            r_acc       <= '0;
            r_len       <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep_cnt <= r_sweep_cnt + hbsd_pkg::STORE_AW'(1);
            end
            if (i_cmd.take) begin
                unique case (i_in.opcode)
                    hbsd_pkg::OP_DECODE: begin
                        r_acc <= n_acc;
                        r_len <= n_len;
                    end
                    hbsd_pkg::OP_END: begin
                        r_acc <= '0;
                        r_len <= '0;
                    end
                    hbsd_pkg::OP_CLEAR, hbsd_pkg::OP_WRITE: begin
                    end
                    default: begin
                    end
                endcase
            end else if (i_cmd.resolve && result) begin
                r_acc <= '0;
                r_len <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resolve && result) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && result) begin
            r_out.decoded_symbol <= hit ? r_rd_data[hbsd_pkg::SYM_W-1:0] : '0;
            r_out.overlong       <= !hit;
        end
    end

    assign o_status.sweep_done     = (r_sweep_cnt == '1);
    assign o_status.result_pending = result;
    assign o_status.out_free       = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* sv/hbsd_ctrl.sv */
// ----------------------------------------------------------------------------
// hbsd_ctrl
// controller: table clearing sweep, beat acceptance and lookup resolution
// ----------------------------------------------------------------------------
module hbsd_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  hbsd_pkg::t_opcode    i_opcode,
    input  hbsd_pkg::t_dp_status i_status,
    output logic                 o_in_stall,
    output hbsd_pkg::t_dp_cmd    o_cmd
);

    hbsd_pkg::t_state r_state;
    hbsd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbsd_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hbsd_pkg::S_CLEAR: begin
                if (i_status.sweep_done) begin
                    n_state = hbsd_pkg::S_IDLE;
                end
            end
            hbsd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_opcode == hbsd_pkg::OP_CLEAR) begin
                        n_state = hbsd_pkg::S_CLEAR;
                    end else if (i_opcode == hbsd_pkg::OP_DECODE) begin
                        n_state = hbsd_pkg::S_RESOLVE;
                    end
                end
            end
            hbsd_pkg::S_RESOLVE: begin
                if (i_status.out_free || !i_status.result_pending) begin
                    n_state = hbsd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = hbsd_pkg::S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = 1'b1;
        o_cmd.take    = 1'b0;
        o_cmd.sweep   = 1'b0;
        o_cmd.resolve = 1'b0;
        unique case (r_state)
            hbsd_pkg::S_CLEAR: begin
                o_cmd.sweep = 1'b1;
            end
            hbsd_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.take = i_in_valid;
            end
            hbsd_pkg::S_RESOLVE: begin
                o_cmd.resolve = i_status.out_free || !i_status.result_pending;
            end
            default: begin
            end
        endcase
    end

endmodule

/* sv/hbsd_checker.sv */
// ----------------------------------------------------------------------------
// hbsd_checker
// port-level checks for the bit-serial huffman decoder
// ----------------------------------------------------------------------------
module hbsd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input hbsd_pkg::t_in_item  i_in,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input hbsd_pkg::t_out_item o_out
);

    logic in_beat;

    assign in_beat = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("output beat dropped or changed while stalled");

    a_overlong_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.overlong) |-> (o_out.decoded_symbol == '0))
        else $error("overlong beat carries a nonzero symbol");

    a_reset_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> o_in_stall)
        else $error("input taken before the table was cleared");

    a_clear_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_in.opcode == hbsd_pkg::OP_CLEAR)) |=> o_in_stall)
        else $error("input taken during a table clear");

    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && (i_in.opcode == hbsd_pkg::OP_DECODE)) |=> o_in_stall)
        else $error("input taken before a decode lookup resolved");

endmodule

bind huffman_bit_serial_decoder hbsd_checker u_hbsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
